// ----- rtl/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// Top-k selector package
// Shared widths, word types and register map of the top-k selector.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int SCORE_W    = 32;
  localparam int INDEX_W    = 10;
  localparam int RANK_W     = 3;
  localparam int TOP_CNT_W  = 4;

  localparam int DEF_MAX_K     = 8;
  localparam int DEF_MAX_ITEMS = 1024;

  localparam logic [TOP_CNT_W-1:0] TOP_COUNT_RESET = 4'd5;

  // Register map: one 32-bit register per word address.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_TOP_COUNT = '0;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      set_end;
  } item_t;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic [INDEX_W-1:0]        class_index;
    logic signed [SCORE_W-1:0] best_score;
    logic                      final_res;
  } result_t;

endpackage

// ----- rtl/tks_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Top-k selector configuration registers
// APB-style register file holding the number of results reported per set.
// ----------------------------------------------------------------------------
module tks_cfg_regs
  import tks_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [TOP_CNT_W-1:0]  top_count
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= TOP_COUNT_RESET;
    end else if (wr_en && (reg_idx == REG_TOP_COUNT)) begin
      top_count <= pwdata[TOP_CNT_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TOP_COUNT: prdata = {{(APB_DATA_W-TOP_CNT_W){1'b0}}, top_count};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- rtl/tks_sorted_list.sv -----
// ----------------------------------------------------------------------------
// Top-k selector sorted list
// Keeps the best MAX_K scores of the current set in descending order, with a
// parallel compare-and-insert per accepted word, and hands a copy of the list
// to the result buffer at the end of a set.
// ----------------------------------------------------------------------------
module tks_sorted_list
  import tks_pkg::*;
#(
  parameter int MAX_K     = DEF_MAX_K,
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  localparam int CW       = $clog2(MAX_K + 1),
  localparam int PW       = $clog2(MAX_ITEMS + 1),
  localparam int IW       = $clog2(MAX_ITEMS)
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  item_t                     item,
  input  logic [TOP_CNT_W-1:0]      top_count,
  output logic                      load,
  output logic signed [SCORE_W-1:0] snap_score [MAX_K],
  output logic [IW-1:0]             snap_index [MAX_K],
  output logic [CW-1:0]             snap_count
);

  localparam int KW = (CW > TOP_CNT_W) ? CW : TOP_CNT_W;

  logic signed [SCORE_W-1:0] kept_score [MAX_K];
  logic [IW-1:0]             kept_index [MAX_K];
  logic [CW-1:0]             kept_count;
  logic [PW-1:0]             next_position;

  logic [CW-1:0] count_next;
  logic [PW-1:0] position_next;
  logic [MAX_K-1:0] take;
  logic [MAX_K-1:0] take_prev;
  logic          pos_ok;
  logic          do_ins;
  logic [KW-1:0] k_req;
  logic [KW-1:0] k_eff;
  logic [KW-1:0] count_wide;

  assign pos_ok = next_position < PW'(MAX_ITEMS);
  assign do_ins = accept && pos_ok;

  // A slot takes the new score when it is empty or holds a score that the new
  // one equals or beats; on a tie the newer, higher index goes first.
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      take[i] = (CW'(i) >= kept_count) || (item.score >= kept_score[i]);
    end
    take_prev[0] = 1'b0;
    for (int i = 1; i < MAX_K; i++) begin
      take_prev[i] = take[i-1];
    end
    for (int i = 0; i < MAX_K; i++) begin
      if (!do_ins || !take[i]) begin
        snap_score[i] = kept_score[i];
        snap_index[i] = kept_index[i];
      end else if (!take_prev[i]) begin
        snap_score[i] = item.score;
        snap_index[i] = IW'(next_position);
      end else begin
        snap_score[i] = kept_score[(i > 0) ? i - 1 : 0];
        snap_index[i] = kept_index[(i > 0) ? i - 1 : 0];
      end
    end
  end

  always_comb begin
    count_next = kept_count;
    if (do_ins && (kept_count < CW'(MAX_K))) begin
      count_next = kept_count + CW'(1);
    end
    position_next = do_ins ? next_position + PW'(1) : next_position;
  end

  always_comb begin
    k_req = KW'(top_count);
    if (k_req == '0) begin
      k_req = KW'(1);
    end
    k_eff      = (k_req > KW'(MAX_K)) ? KW'(MAX_K) : k_req;
    count_wide = KW'(count_next);
    snap_count = CW'((count_wide < k_eff) ? count_wide : k_eff);
  end

  assign load = accept && item.set_end && (snap_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count    <= '0;
      next_position <= '0;
    end else if (accept) begin
      if (item.set_end) begin
        kept_count    <= '0;
        next_position <= '0;
      end else begin
        kept_count    <= count_next;
        next_position <= position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kept_score <= snap_score;
      kept_index <= snap_index;
    end
  end

endmodule

// ----- rtl/tks_result_buf.sv -----
// ----------------------------------------------------------------------------
// Top-k selector result buffer
// Holds the ranked list of a finished set and shifts it out best first, one
// result word per cycle while result_ready is high; the last word is marked.
// ----------------------------------------------------------------------------
module tks_result_buf
  import tks_pkg::*;
#(
  parameter int MAX_K     = DEF_MAX_K,
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  localparam int CW       = $clog2(MAX_K + 1),
  localparam int IW       = $clog2(MAX_ITEMS)
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic signed [SCORE_W-1:0] snap_score [MAX_K],
  input  logic [IW-1:0]             snap_index [MAX_K],
  input  logic [CW-1:0]             snap_count,
  output logic                      load_ok,
  output logic                      result_valid,
  input  logic                      result_ready,
  output result_t                   result
);

  logic signed [SCORE_W-1:0] buf_score [MAX_K];
  logic [IW-1:0]             buf_index [MAX_K];
  logic [CW-1:0]             remain;
  logic [CW-1:0]             rank_cnt;
  logic                      take;

  assign take         = result_valid && result_ready;
  assign result_valid = (remain != '0);
  // A new list may enter once the last word of the current one is leaving.
  assign load_ok      = (remain == '0) || ((remain == CW'(1)) && take);

  assign result.rank        = RANK_W'(rank_cnt);
  assign result.class_index = INDEX_W'(buf_index[0]);
  assign result.best_score  = buf_score[0];
  assign result.final_res   = (remain == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      remain   <= '0;
      rank_cnt <= '0;
    end else if (load) begin
      remain   <= snap_count;
      rank_cnt <= '0;
    end else if (take) begin
      remain   <= remain - CW'(1);
      rank_cnt <= rank_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_score <= snap_score;
      buf_index <= snap_index;
    end else if (take) begin
      for (int i = 0; i < MAX_K - 1; i++) begin
        buf_score[i] <= buf_score[i+1];
        buf_index[i] <= buf_index[i+1];
      end
    end
  end

endmodule

// ----- rtl/top_k_selector.sv -----
// ----------------------------------------------------------------------------
// Top-k selector
// Streaming selection of the best k scores of each set, reported best first.
// ----------------------------------------------------------------------------
// The block takes one score word per cycle, with no gaps needed between words
// or between sets. Each score is ranked against the kept list by parallel
// compares, so the list is current right after every word. The word that
// ends a set emits min(k, scores in set) result words, one per cycle while
// result_ready is high, from a separate buffer while the next set streams in.
// Only a set-ending word can stall: it waits until the previous set's result
// words, up to k of them, have drained down to the final one. top_count is k;
// zero counts as one and values above MAX_K count as MAX_K. The value in force
// when a set's last word is accepted decides that set's count, so it may be
// changed within a set, but only while no word is in flight.
// ----------------------------------------------------------------------------
module top_k_selector
  import tks_pkg::*;
#(
  parameter int MAX_K     = DEF_MAX_K,
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW = $clog2(MAX_K + 1);
  localparam int IW = $clog2(MAX_ITEMS);

  logic [TOP_CNT_W-1:0]      top_count;
  logic                      accept;
  logic                      load;
  logic                      load_ok;
  logic signed [SCORE_W-1:0] snap_score [MAX_K];
  logic [IW-1:0]             snap_index [MAX_K];
  logic [CW-1:0]             snap_count;

  assign item_ready = load_ok || !(item_valid && item.set_end);
  assign accept     = item_valid && item_ready;

  tks_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .top_count (top_count)
  );

  tks_sorted_list #(
    .MAX_K     (MAX_K),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_sorted_list (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .top_count  (top_count),
    .load       (load),
    .snap_score (snap_score),
    .snap_index (snap_index),
    .snap_count (snap_count)
  );

  tks_result_buf #(
    .MAX_K     (MAX_K),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_result_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .snap_score   (snap_score),
    .snap_index   (snap_index),
    .snap_count   (snap_count),
    .load_ok      (load_ok),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Top-k selector testbench
// Streams score sets of mixed lengths through the selector with random sender
// gaps and receiver stalls. A scoreboard keeps its own sorted list of the best
// scores of the current set and checks every ranked result word against it.
// ----------------------------------------------------------------------------

class top_k_scoreboard;
  logic signed [tks_pkg::SCORE_W-1:0] kept_score [tks_pkg::DEF_MAX_K];
  logic [tks_pkg::INDEX_W-1:0]        kept_index [tks_pkg::DEF_MAX_K];
  int                                 kept_count;
  int                                 next_pos;
  logic [tks_pkg::TOP_CNT_W-1:0]      top_count;
  tks_pkg::result_t                   awaited[$];
  int                                 failures;

  function new();
    kept_count = 0;
    next_pos   = 0;
    top_count  = tks_pkg::TOP_COUNT_RESET;
    failures   = 0;
  endfunction

  // Only the first ten failures are printed; the rest are counted.
  function void flag(string msg);
    failures++;
    if (failures <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  function void note_item(tks_pkg::item_t w);
    logic signed [tks_pkg::SCORE_W-1:0] s;
    tks_pkg::result_t                   e;
    int                                 p;
    int                                 last;
    int                                 k;
    int                                 n;
    int                                 i;
    s = w.score;
    // Scores past the end of the index range are dropped.
    if (next_pos < tks_pkg::DEF_MAX_ITEMS) begin
      // A new score goes ahead of the first kept score it equals or beats.
      p = 0;
      while (p < kept_count && s < kept_score[p]) begin
        p++;
      end
      if (p < tks_pkg::DEF_MAX_K) begin
        last = (kept_count < tks_pkg::DEF_MAX_K) ? kept_count : tks_pkg::DEF_MAX_K - 1;
        for (i = last; i > p; i--) begin
          kept_score[i] = kept_score[i-1];
          kept_index[i] = kept_index[i-1];
        end
        kept_score[p] = s;
        kept_index[p] = next_pos[tks_pkg::INDEX_W-1:0];
        if (kept_count < tks_pkg::DEF_MAX_K) begin
          kept_count++;
        end
      end
      next_pos++;
    end
    if (w.set_end) begin
      k = top_count;
      if (k == 0) begin
        k = 1;
      end
      if (k > tks_pkg::DEF_MAX_K) begin
        k = tks_pkg::DEF_MAX_K;
      end
      n = (kept_count < k) ? kept_count : k;
      for (i = 0; i < n; i++) begin
        e.rank        = i[tks_pkg::RANK_W-1:0];
        e.class_index = kept_index[i];
        e.best_score  = kept_score[i];
        e.final_res   = (i == n - 1);
        awaited.insert(awaited.size(), e);
      end
      kept_count = 0;
      next_pos   = 0;
    end
  endfunction

  function void check_result(tks_pkg::result_t got);
    tks_pkg::result_t want;
    if (awaited.size() == 0) begin
      flag($sformatf("unexpected result: rank %0d index %0d score %h final %0b",
                     got.rank, got.class_index, got.best_score, got.final_res));
      return;
    end
    want = awaited.pop_front();
    if (got.rank !== want.rank || got.class_index !== want.class_index ||
        got.best_score !== want.best_score || got.final_res !== want.final_res) begin
      flag($sformatf({"result mismatch: expected rank %0d index %0d score %h final %0b,",
                      " got rank %0d index %0d score %h final %0b"},
                     want.rank, want.class_index, want.best_score, want.final_res,
                     got.rank, got.class_index, got.best_score, got.final_res));
    end
  endfunction
endclass

module testbench;
  import tks_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int BURST_MAX     = 24;
  localparam int RANDOM_ITEMS  = 280;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;
  logic                  result_valid;
  logic                  result_ready;
  result_t               result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  top_k_scoreboard ranking;
  int              burst_left = 0;
  int              stall_mode = 0;
  int              stall_left = 0;

  top_k_selector #(
    .MAX_K     (DEF_MAX_K),
    .MAX_ITEMS (DEF_MAX_ITEMS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // The receiver switches between free flow, random stalls, long stalls and
  // a regular pattern, each for a random stretch of cycles.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      0: result_ready = 1'b1;
      1: result_ready = 1'($urandom_range(0, 1));
      2: result_ready = ($urandom_range(0, 5) == 0);
      default: result_ready = (stall_left % 3) != 0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) begin
        ranking.note_item(item);
      end
      if (result_valid && result_ready) begin
        ranking.check_result(result);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic last);
    if (burst_left == 0) begin
      item_valid = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, BURST_MAX);
    end
    burst_left--;
    item_valid    = 1'b1;
    item.score    = s;
    item.set_end  = last;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  // Tie-heavy sets draw most scores from a handful of small values.
  function automatic logic signed [SCORE_W-1:0] pick_score(input bit tie_heavy);
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return 32'sh7FFFFFFF;
    end else if (roll == 1) begin
      return 32'sh80000000;
    end else if (tie_heavy && roll < 12) begin
      return $signed($urandom_range(0, 6)) - 3;
    end
    return $urandom;
  endfunction

  task automatic send_set(input int len, input bit tie_heavy);
    int i;
    for (i = 0; i < len; i++) begin
      send_score(pick_score(tie_heavy), i == len - 1);
    end
  endtask

  // Stop the sender and wait until the block has nothing left to deliver.
  task automatic settle();
    item_valid = 1'b0;
    while (ranking.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_top_count(input logic [TOP_CNT_W-1:0] v);
    logic [APB_DATA_W-1:0] readback;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {REG_TOP_COUNT, 2'b00};
    pwdata  = '0;
    pwdata[TOP_CNT_W-1:0] = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    ranking.top_count = v;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback[TOP_CNT_W-1:0] !== v) begin
      ranking.flag($sformatf("top_count readback %h, written %h", readback, v));
    end
  endtask

  initial begin
    logic [TOP_CNT_W-1:0] k_settings [8];
    int                   phase;
    int                   phase_items;
    int                   random_items;
    int                   len;
    int                   i;
    logic signed [SCORE_W-1:0] s;

    ranking      = new();
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset count of five: extremes, and ties that must rank the later word first.
    send_score(32'sh7FFFFFFF, 1'b0);
    send_score(32'sh80000000, 1'b0);
    send_score(32'sh00000000, 1'b0);
    send_score(-32'sd1, 1'b0);
    send_score(32'sd1, 1'b0);
    send_score(32'sh00000000, 1'b0);
    send_score(32'sh7FFFFFFF, 1'b1);

    // A count of zero reports one result.
    settle();
    write_top_count(4'd0);
    send_score(-32'sd5, 1'b0);
    send_score(32'sd3, 1'b1);

    // A count above the list size saturates; a one-word set is a short set.
    settle();
    write_top_count(4'd15);
    send_score(32'sh80000000, 1'b1);
    for (i = 0; i < 10; i++) begin
      s = (i == 5) ? 32'sh80000000 : (i == 6) ? 32'sh7FFFFFFF : 32'sd100;
      send_score(s, i == 9);
    end

    // The count in force at the end of a set decides, even if changed mid-set.
    settle();
    send_score(-32'sd7, 1'b0);
    send_score(32'sd42, 1'b0);
    send_score(32'sd9, 1'b0);
    settle();
    write_top_count(4'd2);
    send_score(32'sd11, 1'b0);
    send_score(32'sd42, 1'b1);

    k_settings[0] = 4'd1;
    k_settings[1] = 4'd8;
    k_settings[2] = 4'd3;
    k_settings[3] = 4'd12;
    k_settings[4] = 4'd6;
    k_settings[5] = 4'd0;
    k_settings[6] = 4'd4;
    k_settings[7] = 4'd7;
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      write_top_count(phase < 8 ? k_settings[phase] : 4'($urandom_range(0, 15)));
      phase_items = 0;
      while (phase_items < 40) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 10) : $urandom_range(11, 30);
        send_set(len, 1'($urandom_range(0, 1)));
        phase_items += len;
      end
      random_items += phase_items;
      phase++;
    end

    settle();
    write_top_count(4'd8);
    send_set(6, 1'b1);

    settle();
    if (ranking.failures == 0 && ranking.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
